// ----- hdl/qslerp_pkg.sv -----
// Shared types, constants and helpers for the quaternion slerp pipeline.
package qslerp_pkg;

	typedef logic signed [15:0] q14_t;

	typedef struct packed {
		q14_t from_x;
		q14_t from_y;
		q14_t from_z;
		q14_t from_w;
		q14_t to_x;
		q14_t to_y;
		q14_t to_z;
		q14_t to_w;
		q14_t blend;
	} in_t;

	typedef struct packed {
		q14_t out_x;
		q14_t out_y;
		q14_t out_z;
		q14_t out_w;
	} out_t;

	// Blend selection codes
	localparam logic [1:0] MODE_FROM  = 2'd0;
	localparam logic [1:0] MODE_TO    = 2'd1;
	localparam logic [1:0] MODE_LIN   = 2'd2;
	localparam logic [1:0] MODE_SLERP = 2'd3;

	localparam logic signed [16:0] QONE = 17'sd16384;
	localparam int SQ_BITS  = 15;
	localparam int DIV_BITS = 32;
	localparam int ATAN_N   = 24;

	typedef logic signed [33:0] cq_t;

	localparam cq_t GAIN_INV = 34'sd652032874;

	localparam cq_t ATAN_Q30 [ATAN_N] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
		34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
		34'sd1024,      34'sd512,       34'sd256,       34'sd128
	};

	typedef struct packed {
		cq_t x;
		cq_t y;
		cq_t z;
	} cordic_t;

	typedef struct packed {
		logic [29:0] rem;
		logic [29:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] num;
		logic [16:0] rem;
		logic [31:0] quo;
		logic [16:0] den;
		logic        neg;
	} div_t;

	// Per-transaction data that rides beside the arithmetic cells
	typedef struct packed {
		logic [1:0]       mode;
		logic             neg;
		q14_t [3:0]       a;
		q14_t [3:0]       b;
		q14_t             t;
		logic [15:0]      c;
		logic [15:0]      sw;
	} side_t;

	// Clamp to the signed 16-bit range
	function automatic q14_t sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) begin
			return 16'sh7fff;
		end else if (v < -48'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

// ----- hdl/qslerp_sqrt_cell.sv -----
// One restoring square root cell: resolves one root bit per cycle.
module qslerp_sqrt_cell (
	input  logic               clk,
	input  logic [3:0]         k,
	input  qslerp_pkg::sqrt_t  din,
	output qslerp_pkg::sqrt_t  dout
);

	logic [29:0]       bitv;
	logic [29:0]       trial;
	qslerp_pkg::sqrt_t nxt;

	// Try the current root bit and keep it when it fits
	always_comb begin
		bitv  = 30'd1 << {k, 1'b0};
		trial = din.root + bitv;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + bitv;
		end else begin
			nxt.rem  = din.rem;
			nxt.root = din.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// ----- hdl/qslerp_cordic_cell.sv -----
// One CORDIC micro-rotation cell, vectoring or rotation by a select input.
module qslerp_cordic_cell (
	input  logic                 clk,
	input  logic [4:0]           idx,
	input  logic                 vec,
	input  qslerp_pkg::cordic_t  din,
	output qslerp_pkg::cordic_t  dout
);

	qslerp_pkg::cq_t     dx;
	qslerp_pkg::cq_t     dy;
	qslerp_pkg::cq_t     at;
	logic                up;
	qslerp_pkg::cordic_t nxt;

	// Pick the turn direction and apply one shift-add step
	always_comb begin
		dx = din.y >>> idx;
		dy = din.x >>> idx;
		at = qslerp_pkg::ATAN_Q30[idx];
		up = vec ? (din.y > 34'sd0) : (din.z < 34'sd0);
		if (up) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + at;
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - at;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// ----- hdl/qslerp_div_cell.sv -----
// One restoring division cell: produces one quotient bit per cycle.
module qslerp_div_cell (
	input  logic              clk,
	input  qslerp_pkg::div_t  din,
	output qslerp_pkg::div_t  dout
);

	logic [17:0]      r;
	logic [17:0]      diff;
	logic             ge;
	qslerp_pkg::div_t nxt;

	// Bring down the next dividend bit and subtract when it fits
	always_comb begin
		r    = {din.rem, din.num[31]};
		diff = r - {1'b0, din.den};
		ge   = r >= {1'b0, din.den};
		nxt      = din;
		nxt.num  = {din.num[30:0], 1'b0};
		nxt.rem  = ge ? diff[16:0] : r[16:0];
		nxt.quo  = {din.quo[30:0], ge};
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

// ----- hdl/quaternion_slerp_top.sv -----
// Top level of the pipelined quaternion slerp block.
// Takes one transaction per clock: busy is never raised, so start may be held
// high every cycle. The pipeline depth depends on N, where N is CORDIC_STAGES
// capped at 24; the depth is set by the chains of cells (15 square-root cells,
// N vectoring cells, N rotation cells, 32 division cells) plus the dot-product
// and blend stages; the result is registered at the output. done is high for
// exactly one cycle per result and the receiver must take it then. The
// linear_threshold register takes a write in any cycle (cfg_ready stays high);
// write it only while no transaction is in flight.
module quaternion_slerp_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qslerp_pkg::in_t   item,
	output logic              done,
	output qslerp_pkg::out_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	localparam int N         = (CORDIC_STAGES < qslerp_pkg::ATAN_N) ?
	                           CORDIC_STAGES : qslerp_pkg::ATAN_N;
	localparam int S_SQ_END  = 4 + qslerp_pkg::SQ_BITS;
	localparam int S_VEC_END = S_SQ_END + N;
	localparam int S_ANG     = S_VEC_END + 1;
	localparam int S_ROT_END = S_ANG + N;
	localparam int S_DIV_END = S_ROT_END + qslerp_pkg::DIV_BITS;
	localparam int S_SEL     = S_DIV_END + 1;
	localparam int S_MUL     = S_SEL + 1;
	localparam int LAT       = S_MUL + 1;

	logic [7:0]               thr_q;
	logic [LAT:1]             vld_q;
	logic                     take;

	qslerp_pkg::q14_t         av [4];
	qslerp_pkg::q14_t         bv [4];
	logic                     same;
	qslerp_pkg::side_t        side_in;
	qslerp_pkg::side_t        side_q [1:LAT-1];
	qslerp_pkg::side_t        side3_n;
	qslerp_pkg::side_t        sw_n;

	logic signed [31:0]       prod_s1 [4];
	logic signed [33:0]       dot_s2;
	logic signed [33:0]       dsh;
	qslerp_pkg::q14_t         craw;
	qslerp_pkg::q14_t         cn;
	logic                     cneg;
	logic                     lin;
	logic [31:0]              csq_s4;

	qslerp_pkg::sqrt_t        sq_d [0:qslerp_pkg::SQ_BITS];
	qslerp_pkg::cordic_t      cv_d [0:N];
	qslerp_pkg::cordic_t      r0_d [0:N];
	qslerp_pkg::cordic_t      r1_d [0:N];
	qslerp_pkg::div_t         d0_d [0:qslerp_pkg::DIV_BITS];
	qslerp_pkg::div_t         d1_d [0:qslerp_pkg::DIV_BITS];

	logic signed [16:0]       wt0;
	logic signed [16:0]       wt1;
	logic signed [50:0]       ap0;
	logic signed [50:0]       ap1;
	qslerp_pkg::q14_t         s0_n;
	qslerp_pkg::q14_t         s1_n;
	qslerp_pkg::q14_t         s0_q;
	qslerp_pkg::q14_t         s1_q;
	qslerp_pkg::q14_t         bn [4];
	logic signed [31:0]       m0_q [4];
	logic signed [31:0]       m1_q [4];
	qslerp_pkg::q14_t         res [4];
	qslerp_pkg::out_t         out_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign take      = start & ~busy;

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Advance the valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-1:1], take};
		end
	end

	// Unpack the transaction and classify the blend factor
	always_comb begin
		av[0] = item.from_x;
		av[1] = item.from_y;
		av[2] = item.from_z;
		av[3] = item.from_w;
		bv[0] = item.to_x;
		bv[1] = item.to_y;
		bv[2] = item.to_z;
		bv[3] = item.to_w;
		same  = (av[0] == bv[0]) && (av[1] == bv[1]) &&
		        (av[2] == bv[2]) && (av[3] == bv[3]);
		side_in      = '0;
		side_in.t    = item.blend;
		for (int k = 0; k < 4; k++) begin
			side_in.a[k] = av[k];
			side_in.b[k] = bv[k];
		end
		if (item.blend <= 16'sd0) begin
			side_in.mode = qslerp_pkg::MODE_FROM;
		end else if ((item.blend >= 16'sd16384) || same) begin
			side_in.mode = qslerp_pkg::MODE_TO;
		end else begin
			side_in.mode = qslerp_pkg::MODE_SLERP;
		end
	end

	// Form the cosine, fold to the short arc, choose linear blending when close
	always_comb begin
		dsh  = dot_s2 >>> 14;
		craw = qslerp_pkg::sat16(48'(dsh));
		cneg = craw < 16'sd0;
		cn   = cneg ? qslerp_pkg::sat16(-48'(craw)) : craw;
		lin  = (qslerp_pkg::QONE - $signed({1'b0, cn})) <= $signed({9'd0, thr_q});
		side3_n      = side_q[2];
		side3_n.neg  = cneg;
		side3_n.c    = cn;
		if ((side_q[2].mode == qslerp_pkg::MODE_SLERP) && lin) begin
			side3_n.mode = qslerp_pkg::MODE_LIN;
		end
		sw_n    = side_q[S_SQ_END];
		sw_n.sw = sq_d[qslerp_pkg::SQ_BITS].root[15:0];
	end

	// Front stages: products, dot sum, square of the cosine
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			prod_s1[k] <= av[k] * bv[k];
		end
		dot_s2 <= 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		csq_s4 <= side_q[3].c * side_q[3].c;
	end

	// Advance the side line, filling in the cosine and sine when known
	always_ff @(posedge clk) begin
		side_q[1] <= side_in;
		for (int s = 2; s < LAT; s++) begin
			if (s == 3) begin
				side_q[s] <= side3_n;
			end else if (s == S_SQ_END + 1) begin
				side_q[s] <= sw_n;
			end else begin
				side_q[s] <= side_q[s-1];
			end
		end
	end

	// Square root of one minus the squared cosine
	assign sq_d[0].rem  = 30'h1000_0000 - csq_s4[29:0];
	assign sq_d[0].root = '0;

	for (genvar j = 0; j < qslerp_pkg::SQ_BITS; j++) begin : g_sq
		qslerp_sqrt_cell u_cell (
			.clk  (clk),
			.k    (4'(qslerp_pkg::SQ_BITS - 1 - j)),
			.din  (sq_d[j]),
			.dout (sq_d[j+1])
		);
	end

	// Angle from (cos, sin) by vectoring
	assign cv_d[0].x = {2'b00, side_q[S_SQ_END].c, 16'h0000};
	assign cv_d[0].y = {2'b00, sq_d[qslerp_pkg::SQ_BITS].root[15:0], 16'h0000};
	assign cv_d[0].z = '0;

	for (genvar j = 0; j < N; j++) begin : g_vec
		qslerp_cordic_cell u_cell (
			.clk  (clk),
			.idx  (5'(j)),
			.vec  (1'b1),
			.din  (cv_d[j]),
			.dout (cv_d[j+1])
		);
	end

	// Scale the angle by each weight
	always_comb begin
		wt1 = $signed({side_q[S_VEC_END].t[15], side_q[S_VEC_END].t});
		wt0 = qslerp_pkg::QONE - wt1;
		ap0 = cv_d[N].z * wt0;
		ap1 = cv_d[N].z * wt1;
	end

	always_ff @(posedge clk) begin
		r0_d[0].x <= qslerp_pkg::GAIN_INV;
		r0_d[0].y <= '0;
		r0_d[0].z <= ap0[47:14];
		r1_d[0].x <= qslerp_pkg::GAIN_INV;
		r1_d[0].y <= '0;
		r1_d[0].z <= ap1[47:14];
	end

	// Sines of both angles by rotation
	for (genvar j = 0; j < N; j++) begin : g_rot
		qslerp_cordic_cell u_cell0 (
			.clk  (clk),
			.idx  (5'(j)),
			.vec  (1'b0),
			.din  (r0_d[j]),
			.dout (r0_d[j+1])
		);
		qslerp_cordic_cell u_cell1 (
			.clk  (clk),
			.idx  (5'(j)),
			.vec  (1'b0),
			.din  (r1_d[j]),
			.dout (r1_d[j+1])
		);
	end

	// Divide each sine by four times the sine of the full angle
	always_comb begin
		d0_d[0].neg = r0_d[N].y < 34'sd0;
		d0_d[0].num = d0_d[0].neg ? 32'(-r0_d[N].y) : 32'(r0_d[N].y);
		d0_d[0].rem = '0;
		d0_d[0].quo = '0;
		d0_d[0].den = {side_q[S_ROT_END].sw[14:0], 2'b00};
		d1_d[0].neg = r1_d[N].y < 34'sd0;
		d1_d[0].num = d1_d[0].neg ? 32'(-r1_d[N].y) : 32'(r1_d[N].y);
		d1_d[0].rem = '0;
		d1_d[0].quo = '0;
		d1_d[0].den = {side_q[S_ROT_END].sw[14:0], 2'b00};
	end

	for (genvar j = 0; j < qslerp_pkg::DIV_BITS; j++) begin : g_div
		qslerp_div_cell u_cell0 (
			.clk  (clk),
			.din  (d0_d[j]),
			.dout (d0_d[j+1])
		);
		qslerp_div_cell u_cell1 (
			.clk  (clk),
			.din  (d1_d[j]),
			.dout (d1_d[j+1])
		);
	end

	// Select the final weights
	always_comb begin
		if (side_q[S_DIV_END].mode == qslerp_pkg::MODE_LIN) begin
			s0_n = 16'(qslerp_pkg::QONE - $signed({side_q[S_DIV_END].t[15],
			                                       side_q[S_DIV_END].t}));
			s1_n = side_q[S_DIV_END].t;
		end else begin
			s0_n = qslerp_pkg::sat16(d0_d[qslerp_pkg::DIV_BITS].neg ?
			       -$signed({16'd0, d0_d[qslerp_pkg::DIV_BITS].quo}) :
			       $signed({16'd0, d0_d[qslerp_pkg::DIV_BITS].quo}));
			s1_n = qslerp_pkg::sat16(d1_d[qslerp_pkg::DIV_BITS].neg ?
			       -$signed({16'd0, d1_d[qslerp_pkg::DIV_BITS].quo}) :
			       $signed({16'd0, d1_d[qslerp_pkg::DIV_BITS].quo}));
		end
	end

	// Negate the end quaternion on the short arc
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			bn[k] = side_q[S_SEL].neg ?
			        qslerp_pkg::sat16(-48'($signed(side_q[S_SEL].b[k]))) :
			        $signed(side_q[S_SEL].b[k]);
		end
	end

	always_ff @(posedge clk) begin
		s0_q <= s0_n;
		s1_q <= s1_n;
		for (int k = 0; k < 4; k++) begin
			m0_q[k] <= s0_q * $signed(side_q[S_SEL].a[k]);
			m1_q[k] <= s1_q * bn[k];
		end
	end

	// Sum the weighted components or pass an input through
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			unique case (side_q[S_MUL].mode)
				qslerp_pkg::MODE_FROM: res[k] = $signed(side_q[S_MUL].a[k]);
				qslerp_pkg::MODE_TO:   res[k] = $signed(side_q[S_MUL].b[k]);
				default:               res[k] = qslerp_pkg::sat16(
				                                (48'(m0_q[k]) + 48'(m1_q[k])) >>> 14);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		out_q.out_x <= res[0];
		out_q.out_y <= res[1];
		out_q.out_z <= res[2];
		out_q.out_w <= res[3];
	end

	assign done   = vld_q[LAT];
	assign result = out_q;

endmodule
